// ===== hdl/b64d_pkg.sv =====
package b64d_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } b64d_out_t;

  // One group of results from up to four characters: up to three bytes, first byte on top.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  num;
    logic        has_data;
    logic        last;
  } b64d_grp_t;

  // Bit 6 set means the code is outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == CharPlus) begin
      s = 7'd62;
    end else if (c == CharSlash) begin
      s = 7'd63;
    end else begin
      s = 7'd64;
    end
    return s;
  endfunction

endpackage

// ===== hdl/b64d_front.sv =====
module b64d_front
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      chr_valid,
  output logic      chr_stall,
  input  b64d_in_t  chr,
  input  logic      q_full,
  output logic      push,
  output b64d_grp_t grp
);

  logic [1:0]  cnt;
  logic [17:0] acc;
  logic        stopped;

  logic [6:0]  sx;
  logic        hit;
  logic        accept;
  logic        grp_full;
  logic [23:0] v;
  logic [1:0]  cnt_upd;
  logic [17:0] acc_upd;
  logic        stopped_upd;

  assign chr_stall = q_full;
  assign accept    = chr_valid && !q_full;

  always_comb begin
    sx          = sextet_of(chr.char_code);
    hit         = !stopped && !sx[6];
    v           = {acc, sx[5:0]};
    grp_full    = hit && (cnt == 2'd3);
    stopped_upd = stopped || sx[6];
    cnt_upd     = cnt;
    acc_upd     = acc;
    if (hit) begin
      if (cnt == 2'd3) begin
        cnt_upd = 2'd0;
        acc_upd = '0;
      end else begin
        cnt_upd = cnt + 2'd1;
        acc_upd = v[17:0];
      end
    end

    // Full group first; otherwise flush what is held at message end.
    if (grp_full) begin
      grp = '{bytes: v, num: 2'd3, has_data: 1'b1, last: chr.end_of_message};
    end else begin
      case (cnt_upd)
        2'd2: grp = '{bytes: {acc_upd[11:4], 16'h0000}, num: 2'd1,
                      has_data: 1'b1, last: 1'b1};
        2'd3: grp = '{bytes: {acc_upd[17:10], acc_upd[9:2], 8'h00}, num: 2'd2,
                      has_data: 1'b1, last: 1'b1};
        default: grp = '{bytes: 24'h000000, num: 2'd1, has_data: 1'b0, last: 1'b1};
      endcase
    end
    push = accept && (grp_full || chr.end_of_message);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      acc     <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      if (chr.end_of_message) begin
        cnt     <= '0;
        acc     <= '0;
        stopped <= 1'b0;
      end else begin
        cnt     <= cnt_upd;
        acc     <= acc_upd;
        stopped <= stopped_upd;
      end
    end
  end

endmodule

// ===== hdl/b64d_queue.sv =====
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b64d_grp_t push_grp,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output b64d_grp_t q_grp
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  b64d_grp_t           entries [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_grp   = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/b64d_back.sv =====
module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  b64d_grp_t q_grp,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output b64d_out_t res
);

  logic [23:0] bytes;
  logic [1:0]  rem;
  logic        has_data;
  logic        grp_last;
  logic        busy;
  logic        xfer;
  logic        final_item;

  assign xfer       = busy && !res_stall;
  assign final_item = (rem == 2'd1);
  assign pop        = q_valid && (!busy || (xfer && final_item));

  assign res_valid     = busy;
  assign res.data_byte = bytes[23:16];
  assign res.has_data  = has_data;
  assign res.last      = grp_last && final_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (xfer && final_item) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes    <= q_grp.bytes;
      rem      <= q_grp.num;
      has_data <= q_grp.has_data;
      grp_last <= q_grp.last;
    end else if (xfer && !final_item) begin
      // advance to the next byte of the group
      bytes <= {bytes[15:0], 8'h00};
      rem   <= rem - 2'd1;
    end
  end

endmodule

// ===== hdl/base64_decoder_core.sv =====
// Streaming base64 decoder: takes one character per cycle on chr while
// chr_stall is low and sends decoded bytes on res, one per cycle while
// res_stall is low. Each character is classified and folded into the current
// group at once; a finished group (three bytes, the tail bytes at message end,
// or an empty end marker) goes into a queue of QUEUE_DEPTH groups, and the
// output side spells it out one byte at a time. A message never yields more
// results than it has characters, so chr_stall rises only while the queue is
// full, which happens only when res is stalled.
module base64_decoder_core
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      chr_valid,
  output logic      chr_stall,
  input  b64d_in_t  chr,
  output logic      res_valid,
  input  logic      res_stall,
  output b64d_out_t res
);

  logic      push;
  b64d_grp_t push_grp;
  logic      q_full;
  logic      pop;
  logic      q_valid;
  b64d_grp_t q_grp;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr),
    .q_full    (q_full),
    .push      (push),
    .grp       (push_grp)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_grp    (q_grp)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_grp     (q_grp),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== hdl/b64d_checker.sv =====
module b64d_checker
  import b64d_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      chr_valid,
  input logic      chr_stall,
  input b64d_in_t  chr,
  input logic      res_valid,
  input logic      res_stall,
  input b64d_out_t res
);

  a_chr_hold: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr_stall |=> chr_valid && $stable(chr))
    else $error("stalled character changed");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_data |-> res.last)
    else $error("empty marker without end mark");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_data |-> res.data_byte == 8'h00)
    else $error("empty marker carries a byte");

endmodule

bind base64_decoder_core b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst       (rst),
  .chr_valid (chr_valid),
  .chr_stall (chr_stall),
  .chr       (chr),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
